[design/nnu_pkg.sv]
// Shared types and constants of the nearest-neighbour upscaler.
// No dependencies; every other file of the block but nnu_ram imports this package.
`default_nettype none

package nnu_pkg;

    localparam int MAX_SCALE   = 16;
    localparam int LINE_PIXELS = 1024;
    localparam int Q_DEPTH     = 4;

    localparam int PIX_W   = 24;
    localparam int CFG_W   = 11;
    localparam int SCALE_W = $clog2(MAX_SCALE + 1);
    localparam int PASS_W  = $clog2(MAX_SCALE);
    localparam int ROW_W   = $clog2(LINE_PIXELS + 1);
    localparam int COL_W   = $clog2(LINE_PIXELS);
    localparam int QPTR_W  = $clog2(Q_DEPTH);
    localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

    localparam logic CMD_PIXEL  = 1'b0;
    localparam logic CMD_REPLAY = 1'b1;

    typedef enum logic [1:0] {
        ST_OK              = 2'd0,
        ST_PIXEL_IN_REPLAY = 2'd1,
        ST_NOTHING_OWED    = 2'd2
    } t_status;

    typedef enum logic {
        CFG_SCALE      = 1'b0,
        CFG_ROW_PIXELS = 1'b1
    } t_cfg_index;

    typedef struct packed {
        logic [PIX_W-1:0]   pixel;
        logic [SCALE_W-1:0] copies;
        logic               end_row;
        logic [1:0]         pad;
        t_status            status;
    } t_entry;

    typedef struct packed {
        logic              empty;
        logic              full;
        logic [QCNT_W-1:0] count;
    } t_q_status;

endpackage

`default_nettype wire

[design/nnu_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module nnu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

[design/nnu_front.sv]
// Front end: accepts commands, tracks fill and replay columns, owns the line buffer.
// Depends on nnu_pkg and nnu_ram; pushes one descriptor per accepted input beat.
`default_nettype none

module nnu_front import nnu_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    input  wire logic               i_command,
    input  wire logic [7:0]         i_blue,
    input  wire logic [7:0]         i_green,
    input  wire logic [7:0]         i_red,
    input  wire logic [SCALE_W-1:0] i_scale,
    input  wire logic [ROW_W-1:0]   i_row,
    input  wire logic [1:0]         i_pad,
    input  wire t_q_status          i_q,
    output logic                    o_stall,
    output logic                    o_push,
    output t_entry                  o_push_entry
);

    localparam logic [COL_W-1:0] COL_MAX = COL_W'(LINE_PIXELS - 1);

    logic [COL_W-1:0]  r_fill, n_fill;
    logic [COL_W-1:0]  r_replay, n_replay;
    logic [PASS_W-1:0] r_passes, n_passes;
    logic              r_s2_valid;
    logic              r_s2_from_ram, n_s2_from_ram;
    t_entry            r_s2_entry, n_s2_entry;

    logic              accept;
    logic              ram_we;
    logic [COL_W-1:0]  fill_col;
    logic [COL_W-1:0]  replay_col;
    logic              fill_end;
    logic              replay_end;
    logic [PIX_W-1:0]  ram_rdata;

    assign o_stall = (QCNT_W'(i_q.count + QCNT_W'(r_s2_valid)) >= QCNT_W'(Q_DEPTH));
    assign accept  = i_valid && !o_stall;

    assign fill_col   = (r_fill >= COL_MAX) ? COL_MAX : r_fill;
    assign replay_col = (r_replay >= COL_MAX) ? COL_MAX : r_replay;
    assign fill_end   = (ROW_W'(ROW_W'(fill_col) + ROW_W'(1)) >= i_row);
    assign replay_end = (ROW_W'(ROW_W'(replay_col) + ROW_W'(1)) >= i_row);

    always_comb begin
        n_fill         = r_fill;
        n_replay       = r_replay;
        n_passes       = r_passes;
        ram_we         = 1'b0;
        n_s2_from_ram  = 1'b0;
        n_s2_entry     = '0;
        n_s2_entry.copies = SCALE_W'(1);
        n_s2_entry.status = ST_OK;
        if (accept) begin
            unique case (i_command)
                CMD_PIXEL: begin
                    if (r_passes != '0) begin
                        n_s2_entry.status = ST_PIXEL_IN_REPLAY;
                    end else begin
                        ram_we             = 1'b1;
                        n_s2_entry.pixel   = {i_red, i_green, i_blue};
                        n_s2_entry.copies  = i_scale;
                        n_s2_entry.end_row = fill_end;
                        n_s2_entry.pad     = fill_end ? i_pad : 2'd0;
                        if (fill_end) begin
                            n_fill   = '0;
                            n_replay = '0;
                            n_passes = PASS_W'(i_scale - SCALE_W'(1));
                        end else begin
                            n_fill = COL_W'(fill_col + COL_W'(1));
                        end
                    end
                end
                CMD_REPLAY: begin
                    if (r_passes == '0) begin
                        n_s2_entry.status = ST_NOTHING_OWED;
                    end else begin
                        n_s2_from_ram      = 1'b1;
                        n_s2_entry.copies  = i_scale;
                        n_s2_entry.end_row = replay_end;
                        n_s2_entry.pad     = replay_end ? i_pad : 2'd0;
                        if (replay_end) begin
                            n_replay = '0;
                            n_passes = PASS_W'(r_passes - PASS_W'(1));
                        end else begin
                            n_replay = COL_W'(replay_col + COL_W'(1));
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill     <= '0;
            r_replay   <= '0;
            r_passes   <= '0;
            r_s2_valid <= 1'b0;
        end else begin
            r_fill     <= n_fill;
            r_replay   <= n_replay;
            r_passes   <= n_passes;
            r_s2_valid <= accept;
        end
        r_s2_from_ram <= n_s2_from_ram;
        r_s2_entry    <= n_s2_entry;
    end

    nnu_ram #(
        .WIDTH (PIX_W),
        .DEPTH (LINE_PIXELS)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (fill_col),
        .i_wdata ({i_red, i_green, i_blue}),
        .i_raddr (replay_col),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        o_push_entry = r_s2_entry;
        if (r_s2_from_ram) begin
            o_push_entry.pixel = ram_rdata;
        end
    end

    assign o_push = r_s2_valid;

endmodule

`default_nettype wire

[design/nnu_queue.sv]
// Short descriptor queue between the front end and the replicating back end.
// Depends on nnu_pkg; head entry is visible while the queue is not empty.
`default_nettype none

module nnu_queue import nnu_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_entry i_push_entry,
    input  wire logic i_pop,
    output t_entry    o_head,
    output t_q_status o_status
);

    t_entry            r_mem [Q_DEPTH];
    logic [QPTR_W-1:0] r_wptr, r_rptr;
    logic [QCNT_W-1:0] r_count, n_count;

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = QCNT_W'(r_count + QCNT_W'(1));
        end else if (!i_push && i_pop) begin
            n_count = QCNT_W'(r_count - QCNT_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wptr <= (r_wptr == QPTR_W'(Q_DEPTH - 1)) ? '0 : QPTR_W'(r_wptr + QPTR_W'(1));
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == QPTR_W'(Q_DEPTH - 1)) ? '0 : QPTR_W'(r_rptr + QPTR_W'(1));
            end
        end
        if (i_push) begin
            r_mem[r_wptr] <= i_push_entry;
        end
    end

    assign o_head         = r_mem[r_rptr];
    assign o_status.empty = (r_count == '0);
    assign o_status.full  = (r_count == QCNT_W'(Q_DEPTH));
    assign o_status.count = r_count;

endmodule

`default_nettype wire

[design/nnu_back.sv]
// Back end: replicates each queued pixel into scale output beats.
// Depends on nnu_pkg; drives the registered output channel.
`default_nettype none

module nnu_back import nnu_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire t_entry i_head,
    input  wire logic   i_empty,
    output logic        o_pop,
    input  wire logic   i_stall,
    output logic        o_valid,
    output logic [7:0]  o_out_blue,
    output logic [7:0]  o_out_green,
    output logic [7:0]  o_out_red,
    output logic [1:0]  o_pad_after,
    output logic        o_row_done,
    output logic [1:0]  o_status,
    output logic        o_last
);

    logic [SCALE_W-1:0] r_copy;
    logic               load;
    logic               fin;

    assign load  = !i_empty && (!o_valid || !i_stall);
    assign fin   = (SCALE_W'(r_copy + SCALE_W'(1)) >= i_head.copies);
    assign o_pop = load && fin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
            r_copy  <= '0;
        end else begin
            if (load) begin
                o_valid <= 1'b1;
                r_copy  <= fin ? '0 : SCALE_W'(r_copy + SCALE_W'(1));
            end else if (!i_stall) begin
                o_valid <= 1'b0;
            end
        end
        if (load) begin
            o_out_blue  <= i_head.pixel[7:0];
            o_out_green <= i_head.pixel[15:8];
            o_out_red   <= i_head.pixel[23:16];
            o_pad_after <= (fin && i_head.end_row) ? i_head.pad : 2'd0;
            o_row_done  <= fin && i_head.end_row;
            o_status    <= i_head.status;
            o_last      <= fin;
        end
    end

endmodule

`default_nettype wire

[design/nearest_neighbour_upscaler_unit.sv]
// Nearest-neighbour integer upscaler: front end, descriptor queue and back end.
// An accepted input beat passes the front-end stage register and the descriptor queue to the back end.
// One output beat per cycle while i_stall is low and the queue holds an item;
// an item gives scale beats (1 to 16) from the back end's single output register.
// Synchronous active-low reset clears columns, owed passes and queue; scale and
// row length return to 1. The line buffer is not cleared and holds no valid bits.
`default_nettype none

module nearest_neighbour_upscaler_unit import nnu_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_stall,
    input  wire logic             i_command,
    input  wire logic [7:0]       i_blue,
    input  wire logic [7:0]       i_green,
    input  wire logic [7:0]       i_red,
    output logic                  o_valid,
    input  wire logic             i_stall,
    output logic [7:0]            o_out_blue,
    output logic [7:0]            o_out_green,
    output logic [7:0]            o_out_red,
    output logic [1:0]            o_pad_after,
    output logic                  o_row_done,
    output logic [1:0]            o_status,
    output logic                  o_last,
    input  wire logic             i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire logic             i_cfg_index,
    input  wire logic [CFG_W-1:0] i_cfg_data
);

    logic [4:0]         r_scale;
    logic [CFG_W-1:0]   r_row;
    logic [SCALE_W-1:0] scale_eff;
    logic [ROW_W-1:0]   row_eff;
    logic [3:0]         pad_prod;
    logic [1:0]         pad;
    t_q_status          q_status;
    t_entry             push_entry;
    t_entry             head;
    logic               push;
    logic               pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= 5'd1;
            r_row   <= CFG_W'(1);
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_SCALE:      r_scale <= i_cfg_data[4:0];
                CFG_ROW_PIXELS: r_row   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        if (r_scale == 5'd0) begin
            scale_eff = SCALE_W'(1);
        end else if (r_scale > 5'(MAX_SCALE)) begin
            scale_eff = SCALE_W'(MAX_SCALE);
        end else begin
            scale_eff = SCALE_W'(r_scale);
        end
        if (r_row == '0) begin
            row_eff = ROW_W'(1);
        end else if (r_row > CFG_W'(LINE_PIXELS)) begin
            row_eff = ROW_W'(LINE_PIXELS);
        end else begin
            row_eff = ROW_W'(r_row);
        end
    end

    // Three bytes per pixel: the pad equals row length times scale, modulo four.
    assign pad_prod = {2'b00, row_eff[1:0]} * {2'b00, scale_eff[1:0]};
    assign pad      = pad_prod[1:0];

    nnu_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_command    (i_command),
        .i_blue       (i_blue),
        .i_green      (i_green),
        .i_red        (i_red),
        .i_scale      (scale_eff),
        .i_row        (row_eff),
        .i_pad        (pad),
        .i_q          (q_status),
        .o_stall      (o_stall),
        .o_push       (push),
        .o_push_entry (push_entry)
    );

    nnu_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_push_entry (push_entry),
        .i_pop        (pop),
        .o_head       (head),
        .o_status     (q_status)
    );

    nnu_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .i_empty     (q_status.empty),
        .o_pop       (pop),
        .i_stall     (i_stall),
        .o_valid     (o_valid),
        .o_out_blue  (o_out_blue),
        .o_out_green (o_out_green),
        .o_out_red   (o_out_red),
        .o_pad_after (o_pad_after),
        .o_row_done  (o_row_done),
        .o_status    (o_status),
        .o_last      (o_last)
    );

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> (!q_status.full || pop))
        else $error("Descriptor queue written while full.");

    a_error_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_OK) |-> (o_last && !o_row_done && o_pad_after == 2'd0))
        else $error("Error beat is not a single plain beat.");

    a_row_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_row_done) |-> o_last)
        else $error("Row end marked on a beat that is not the last copy.");

    a_pad_at_row_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_pad_after != 2'd0) |-> o_row_done)
        else $error("Padding given away from the row end.");

endmodule

`default_nettype wire

[test/nnu_checker.sv]
`timescale 1ns / 100ps
// Checker for the nearest-neighbour upscaler: follows the pixel, result and register channels,
// predicts every result beat and compares it field by field with what the block returns.
// Depends on nnu_pkg for command codes, status codes and register indexes.
module nnu_checker import nnu_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_px_valid,
    input  wire logic              i_px_stall,
    input  wire logic              i_command,
    input  wire logic [7:0]        i_blue,
    input  wire logic [7:0]        i_green,
    input  wire logic [7:0]        i_red,
    input  wire logic              i_res_valid,
    input  wire logic              i_res_stall,
    input  wire logic [7:0]        i_res_blue,
    input  wire logic [7:0]        i_res_green,
    input  wire logic [7:0]        i_res_red,
    input  wire logic [1:0]        i_res_pad_after,
    input  wire logic              i_res_row_done,
    input  wire logic [1:0]        i_res_status,
    input  wire logic              i_res_last,
    input  wire logic              i_cfg_valid,
    input  wire logic              i_cfg_ready,
    input  wire logic              i_cfg_index,
    input  wire logic [CFG_W-1:0]  i_cfg_data,
    output int                     o_fail_count,
    output int                     o_pending,
    output logic [PASS_W-1:0]      o_passes_owed
);

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic [1:0] pad_after;
        logic       row_done;
        t_status    status;
        logic       last;
    } t_out_beat;

    t_out_beat         beats_due[$];
    logic [PIX_W-1:0]  line_store [LINE_PIXELS];
    int unsigned       fill_column   = 0;
    int unsigned       replay_column = 0;
    logic [PASS_W-1:0] passes_owed   = '0;
    logic [4:0]        scale_reg     = 5'd1;
    logic [CFG_W-1:0]  row_reg       = 1;
    int                fail_count    = 0;
    int                pending_count = 0;
    int                beat_count    = 0;

    assign o_fail_count  = fail_count;
    assign o_pending     = pending_count;
    assign o_passes_owed = passes_owed;

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        fail_count++;
    endtask

    task automatic compare_field(input string name, input logic [7:0] got,
                                 input logic [7:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("beat %0d %s: expected %0d, got %0d",
                                      beat_count, name, want, got));
        end
    endtask

    task automatic queue_copies(input logic [PIX_W-1:0] pix, input int unsigned copies,
                                input logic end_row, input logic [1:0] pad);
        t_out_beat b;
        for (int unsigned k = 0; k < copies; k++) begin
            b.blue      = pix[7:0];
            b.green     = pix[15:8];
            b.red       = pix[23:16];
            b.last      = (k + 1 == copies);
            b.row_done  = b.last && end_row;
            b.pad_after = b.row_done ? pad : 2'd0;
            b.status    = ST_OK;
            beats_due.push_back(b);
        end
    endtask

    task automatic queue_error(input t_status code);
        t_out_beat b;
        b        = '0;
        b.status = code;
        b.last   = 1'b1;
        beats_due.push_back(b);
    endtask

    task automatic upscale_item(input logic cmd, input logic [7:0] blue,
                                input logic [7:0] green, input logic [7:0] red);
        int unsigned      s;
        int unsigned      r;
        logic [1:0]       pad;
        logic [PIX_W-1:0] pix;
        logic             end_row;
        s   = (scale_reg == 0) ? 1 : ((scale_reg > MAX_SCALE) ? MAX_SCALE : scale_reg);
        r   = (row_reg == 0) ? 1 : ((row_reg > LINE_PIXELS) ? LINE_PIXELS : row_reg);
        pad = 2'(0 - s * r * 3);
        if (cmd == CMD_PIXEL) begin
            if (passes_owed != 0) begin
                queue_error(ST_PIXEL_IN_REPLAY);
            end else begin
                pix = {red, green, blue};
                if (fill_column >= LINE_PIXELS) fill_column = LINE_PIXELS - 1;
                line_store[fill_column] = pix;
                end_row = (fill_column + 1 >= r);
                if (end_row) begin
                    fill_column   = 0;
                    replay_column = 0;
                    passes_owed   = PASS_W'(s - 1);
                end else begin
                    fill_column++;
                end
                queue_copies(pix, s, end_row, pad);
            end
        end else if (passes_owed == 0) begin
            queue_error(ST_NOTHING_OWED);
        end else begin
            if (replay_column >= LINE_PIXELS) replay_column = LINE_PIXELS - 1;
            pix     = line_store[replay_column];
            end_row = (replay_column + 1 >= r);
            if (end_row) begin
                replay_column = 0;
                passes_owed--;
            end else begin
                replay_column++;
            end
            queue_copies(pix, s, end_row, pad);
        end
    endtask

    task automatic check_beat();
        t_out_beat want;
        if (beats_due.size() == 0) begin
            report_mismatch($sformatf("beat %0d arrived with nothing expected", beat_count));
        end else begin
            want = beats_due.pop_front();
            compare_field("out_blue", i_res_blue, want.blue);
            compare_field("out_green", i_res_green, want.green);
            compare_field("out_red", i_res_red, want.red);
            compare_field("pad_after", 8'(i_res_pad_after), 8'(want.pad_after));
            compare_field("row_done", 8'(i_res_row_done), 8'(want.row_done));
            compare_field("status", 8'(i_res_status), 8'(want.status));
            compare_field("last", 8'(i_res_last), 8'(want.last));
        end
        beat_count++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            fill_column   = 0;
            replay_column = 0;
            passes_owed   = '0;
            scale_reg     = 5'd1;
            row_reg       = 1;
            beats_due.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_SCALE) scale_reg = i_cfg_data[4:0];
                else row_reg = i_cfg_data;
            end
            if (i_px_valid && !i_px_stall) upscale_item(i_command, i_blue, i_green, i_red);
            if (i_res_valid && !i_res_stall) check_beat();
        end
        pending_count = beats_due.size();
    end

endmodule

[test/tb_nearest_neighbour_upscaler_unit.sv]
`timescale 1ns / 100ps
// Testbench top for the nearest-neighbour upscaler: clock, reset, stimulus and verdict.
// Depends on nnu_pkg, the upscaler unit and the nnu_checker module beside it.
module tb_nearest_neighbour_upscaler_unit;
    import nnu_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 94;
    localparam int SETTLE       = 16;

    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             i_valid     = 1'b0;
    logic             i_command   = CMD_PIXEL;
    logic [7:0]       i_blue      = '0;
    logic [7:0]       i_green     = '0;
    logic [7:0]       i_red       = '0;
    logic             i_stall     = 1'b0;
    logic             i_cfg_valid = 1'b0;
    logic             i_cfg_index = CFG_SCALE;
    logic [CFG_W-1:0] i_cfg_data  = '0;

    logic             o_stall;
    logic             o_valid;
    logic [7:0]       o_out_blue;
    logic [7:0]       o_out_green;
    logic [7:0]       o_out_red;
    logic [1:0]       o_pad_after;
    logic             o_row_done;
    logic [1:0]       o_status;
    logic             o_last;
    logic             o_cfg_ready;

    int                fail_count;
    int                pending_beats;
    logic [PASS_W-1:0] passes_owed;
    int                sender_gap_pct     = 0;
    int                receiver_stall_pct = 0;
    int                cycle_count        = 0;
    logic [CFG_W-1:0]  row_setting        = 1;

    nearest_neighbour_upscaler_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_command   (i_command),
        .i_blue      (i_blue),
        .i_green     (i_green),
        .i_red       (i_red),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_out_blue  (o_out_blue),
        .o_out_green (o_out_green),
        .o_out_red   (o_out_red),
        .o_pad_after (o_pad_after),
        .o_row_done  (o_row_done),
        .o_status    (o_status),
        .o_last      (o_last),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    nnu_checker u_nnu_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_px_valid      (i_valid),
        .i_px_stall      (o_stall),
        .i_command       (i_command),
        .i_blue          (i_blue),
        .i_green         (i_green),
        .i_red           (i_red),
        .i_res_valid     (o_valid),
        .i_res_stall     (i_stall),
        .i_res_blue      (o_out_blue),
        .i_res_green     (o_out_green),
        .i_res_red       (o_out_red),
        .i_res_pad_after (o_pad_after),
        .i_res_row_done  (o_row_done),
        .i_res_status    (o_status),
        .i_res_last      (o_last),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_fail_count    (fail_count),
        .o_pending       (pending_beats),
        .o_passes_owed   (passes_owed)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        i_stall = ($urandom_range(0, 99) < receiver_stall_pct);
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic int row_limit(input logic [CFG_W-1:0] v);
        return (v == 0) ? 1 : ((v > LINE_PIXELS) ? LINE_PIXELS : int'(v));
    endfunction

    function automatic logic [7:0] random_byte();
        if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic send_item(input logic cmd, input logic [7:0] blue,
                             input logic [7:0] green, input logic [7:0] red);
        while ($urandom_range(0, 99) < sender_gap_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid   = 1'b1;
        i_command = cmd;
        i_blue    = blue;
        i_green   = green;
        i_red     = red;
        do @(posedge i_clk); while (o_stall);
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_valid = 1'b0;
        while (pending_beats != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_index idx, input logic [CFG_W-1:0] data);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
        if (idx == CFG_ROW_PIXELS) row_setting = data;
    endtask

    initial begin
        int               sent;
        int               phase_len;
        logic [4:0]       new_scale;
        logic [CFG_W-1:0] new_row;
        logic             cmd;

        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        send_item(CMD_REPLAY, 8'h00, 8'h00, 8'h00);
        send_item(CMD_PIXEL, 8'h00, 8'h00, 8'h00);
        send_item(CMD_PIXEL, 8'hFF, 8'hFF, 8'hFF);
        drain();
        write_reg(CFG_SCALE, 3);
        write_reg(CFG_ROW_PIXELS, 2);
        send_item(CMD_PIXEL, 8'h12, 8'h34, 8'h56);
        send_item(CMD_PIXEL, 8'hA5, 8'h5A, 8'hC3);
        send_item(CMD_PIXEL, 8'h01, 8'h02, 8'h03);
        repeat (4) send_item(CMD_REPLAY, 8'hFF, 8'h00, 8'hFF);
        drain();
        write_reg(CFG_SCALE, 0);
        write_reg(CFG_ROW_PIXELS, 0);
        send_item(CMD_PIXEL, 8'h80, 8'h7F, 8'h01);
        drain();
        write_reg(CFG_SCALE, 31);
        write_reg(CFG_ROW_PIXELS, 2047);
        send_item(CMD_PIXEL, 8'hFE, 8'h01, 8'h80);
        send_item(CMD_PIXEL, 8'h55, 8'hAA, 8'h0F);
        drain();
        // The row shrinks under a partly filled line, so the next pixel closes it.
        write_reg(CFG_ROW_PIXELS, 1);
        send_item(CMD_PIXEL, 8'h3C, 8'hC3, 8'h99);
        drain();
        write_reg(CFG_SCALE, 2);
        repeat (2) send_item(CMD_REPLAY, 8'h00, 8'hFF, 8'h00);

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            drain();
            if (sent < RANDOM_ITEMS / 3) begin
                sender_gap_pct     = 15;
                receiver_stall_pct = 50;
            end else if (sent < 2 * RANDOM_ITEMS / 3) begin
                sender_gap_pct     = 50;
                receiver_stall_pct = 15;
            end else begin
                sender_gap_pct     = 0;
                receiver_stall_pct = 0;
            end
            case ($urandom_range(0, 9))
                0:       new_scale = 5'd0;
                1:       new_scale = 5'd16;
                2:       new_scale = 5'($urandom_range(17, 31));
                default: new_scale = 5'($urandom_range(1, 4));
            endcase
            case ($urandom_range(0, 9))
                0:       new_row = '0;
                1:       new_row = 11'd1024;
                2:       new_row = CFG_W'($urandom_range(1025, 2047));
                default: new_row = CFG_W'($urandom_range(1, 5));
            endcase
            write_reg(CFG_SCALE, CFG_W'(new_scale));
            // Growing the row while passes are owed would replay columns never filled.
            if (passes_owed == 0 || row_limit(new_row) <= row_limit(row_setting)) begin
                write_reg(CFG_ROW_PIXELS, new_row);
            end
            phase_len = $urandom_range(6, 16);
            for (int n = 0; n < phase_len && sent < RANDOM_ITEMS; n++) begin
                if (passes_owed != 0) begin
                    cmd = ($urandom_range(0, 99) < 85) ? CMD_REPLAY : CMD_PIXEL;
                end else begin
                    cmd = ($urandom_range(0, 99) < 85) ? CMD_PIXEL : CMD_REPLAY;
                end
                send_item(cmd, random_byte(), random_byte(), random_byte());
                sent++;
            end
        end

        drain();
        if (fail_count == 0 && pending_beats == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
